/* hw/rtl/binary_heap_priority_queue_defines.svh */
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define BHPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/bhpq_pkg.sv */
// Types, constants and helpers for the binary heap priority queue.
package bhpq_pkg;

  localparam int unsigned HEAP_DEPTH  = 128;
  localparam int unsigned IDX_W       = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_W     = IDX_W + 2;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_OUT_W = 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_HEAP_ORDER = 1'b0;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Step commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd_last;
    logic ld_last;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic emit;
  } cmd_t;

  // Decisions reported by the datapath
  typedef struct packed {
    logic req_extract;
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_move;
    logic has_child;
    logic dn_move;
  } sts_t;

  // True when a belongs strictly above b for the selected order
  function automatic logic outranks(logic order, value_t a, value_t b);
    return order ? (a > b) : (a < b);
  endfunction

endpackage

/* hw/rtl/bhpq_if.sv */
// Valid/ready channel interfaces for commands and results.
interface bhpq_in_if import bhpq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   command;
  value_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bhpq_out_if import bhpq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  value_t                 removed_value;
  value_t                 top_value;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic [1:0]             status;

  modport source (output valid, output removed_value, output top_value,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input removed_value, input top_value,
                  input entry_count, input status, output ready);
endinterface

/* hw/rtl/bhpq_datapath.sv */
// Heap storage, sift position, compare logic and result register.
`include "binary_heap_priority_queue_defines.svh"

module bhpq_datapath import bhpq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   order_i,
  input  logic                   command_i,
  input  value_t                 value_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output value_t                 removed_value_o,
  output value_t                 top_value_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o,
  output status_e                status_o
);

  value_t mem [HEAP_DEPTH];

  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  value_t                 val_q, val_d;
  value_t                 root_q, root_d;
  value_t                 removed_q, removed_d;
  status_e                status_q, status_d;
  value_t                 rd_a_q, rd_b_q;
  value_t                 out_removed_q, out_removed_d;
  value_t                 out_top_q, out_top_d;
  logic [COUNT_OUT_W-1:0] out_count_q, out_count_d;
  status_e                out_status_q, out_status_d;

  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_wa, mem_ra, mem_rb;
  value_t                 mem_wd;

  logic [IDX_W-1:0]       parent;
  logic [CHILD_W-1:0]     child_l, child_r, cnt_ext;
  logic                   right_ok, pick_r;
  value_t                 best_val;
  logic [IDX_W-1:0]       best_idx;

  always_comb begin
    parent   = IDX_W'((pos_q - IDX_W'(1)) >> 1);
    child_l  = {1'b0, pos_q, 1'b1};
    child_r  = child_l + CHILD_W'(1);
    cnt_ext  = CHILD_W'(count_q);
    right_ok = child_r < cnt_ext;
    pick_r   = right_ok && outranks(order_i, rd_b_q, rd_a_q);
    best_val = pick_r ? rd_b_q : rd_a_q;
    best_idx = pick_r ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
  end

  always_comb begin
    sts_o.req_extract = (command_i == CMD_EXTRACT);
    sts_o.full        = (count_q == CNT_W'(HEAP_DEPTH));
    sts_o.empty       = (count_q == '0);
    sts_o.last_one    = (count_q == CNT_W'(1));
    sts_o.at_root     = (pos_q == '0);
    sts_o.up_move     = outranks(order_i, val_q, rd_a_q);
    sts_o.has_child   = (child_l < cnt_ext);
    sts_o.dn_move     = outranks(order_i, best_val, val_q);
  end

  always_comb begin
    count_d       = count_q;
    pos_d         = pos_q;
    val_d         = val_q;
    removed_d     = removed_q;
    status_d      = status_q;
    out_removed_d = out_removed_q;
    out_top_d     = out_top_q;
    out_count_d   = out_count_q;
    out_status_d  = out_status_q;
    mem_we        = 1'b0;
    mem_wa        = pos_q;
    mem_wd        = val_q;
    mem_re        = 1'b0;
    mem_ra        = parent;
    mem_rb        = child_r[IDX_W-1:0];

    if (cmd_i.accept) begin
      status_d  = STATUS_OK;
      removed_d = '0;
      if (command_i == CMD_EXTRACT) begin
        if (sts_o.empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          removed_d = root_q;
          count_d   = count_q - CNT_W'(1);
          pos_d     = '0;
        end
      end else begin
        if (sts_o.full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
          pos_d   = count_q[IDX_W-1:0];
          val_d   = value_i;
        end
      end
    end

    // Fetch the last entry, which moves to the root
    if (cmd_i.rd_last) begin
      mem_re = 1'b1;
      mem_ra = count_q[IDX_W-1:0];
    end

    if (cmd_i.ld_last) begin
      val_d = rd_a_q;
    end

    if (cmd_i.up_rd) begin
      if (sts_o.at_root) begin
        mem_we = 1'b1;
      end else begin
        mem_re = 1'b1;
      end
    end

    // Pull the parent down into the hole, or drop the value in place
    if (cmd_i.up_cmp) begin
      mem_we = 1'b1;
      if (sts_o.up_move) begin
        mem_wd = rd_a_q;
        pos_d  = parent;
      end
    end

    if (cmd_i.dn_rd) begin
      if (sts_o.has_child) begin
        mem_re = 1'b1;
        mem_ra = child_l[IDX_W-1:0];
      end else begin
        mem_we = 1'b1;
      end
    end

    // Lift the better child into the hole, or drop the value in place
    if (cmd_i.dn_cmp) begin
      mem_we = 1'b1;
      if (sts_o.dn_move) begin
        mem_wd = best_val;
        pos_d  = best_idx;
      end
    end

    if (cmd_i.emit) begin
      out_removed_d = removed_q;
      out_top_d     = (count_q != '0) ? root_q : '0;
      out_count_d   = COUNT_OUT_W'(count_q);
      out_status_d  = status_q;
    end
  end

  assign root_d = (mem_we && (mem_wa == '0)) ? mem_wd : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    val_q         <= val_d;
    root_q        <= root_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    out_removed_q <= out_removed_d;
    out_top_q     <= out_top_d;
    out_count_q   <= out_count_d;
    out_status_q  <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_a_q <= mem[mem_ra];
      rd_b_q <= mem[mem_rb];
    end
  end

  assign removed_value_o = out_removed_q;
  assign top_value_o     = out_top_q;
  assign entry_count_o   = out_count_q;
  assign status_o        = out_status_q;

  `BHPQ_ASSERT(a_count_bound, count_q <= CNT_W'(HEAP_DEPTH), "entry count above depth")
  `BHPQ_ASSERT(a_write_in_range, !mem_we || (CNT_W'(mem_wa) < count_q), "write beyond held entries")
  `BHPQ_ASSERT_NEXT(a_count_only_on_accept, !cmd_i.accept, $stable(count_q), "count moved without a transfer")

endmodule

/* hw/rtl/bhpq_ctrl.sv */
// Controller state machine sequencing insert and extract sifts.
`include "binary_heap_priority_queue_defines.svh"

module bhpq_ctrl import bhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RD_LAST = 8'b0000_0010,
    S_LD_LAST = 8'b0000_0100,
    S_UP_RD   = 8'b0000_1000,
    S_UP_CMP  = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_last  = (state_q == S_RD_LAST);
    cmd_o.ld_last  = (state_q == S_LD_LAST);
    cmd_o.up_rd    = (state_q == S_UP_RD);
    cmd_o.up_cmp   = (state_q == S_UP_CMP);
    cmd_o.dn_rd    = (state_q == S_DN_RD);
    cmd_o.dn_cmp   = (state_q == S_DN_CMP);
    out_valid_d    = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.req_extract) begin
            // Nothing to sift when the heap is empty or drains to zero
            if (sts_i.empty || sts_i.last_one) begin
              state_d = S_DONE;
            end else begin
              state_d = S_RD_LAST;
            end
          end else begin
            state_d = sts_i.full ? S_DONE : S_UP_RD;
          end
        end
      end
      S_RD_LAST: begin
        state_d = S_LD_LAST;
      end
      S_LD_LAST: begin
        state_d = S_DN_RD;
      end
      S_UP_RD: begin
        state_d = sts_i.at_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_d = sts_i.up_move ? S_UP_RD : S_DONE;
      end
      S_DN_RD: begin
        state_d = sts_i.has_child ? S_DN_CMP : S_DONE;
      end
      S_DN_CMP: begin
        state_d = sts_i.dn_move ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BHPQ_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE, "stayed idle after transfer")
  `BHPQ_ASSERT(a_cmp_not_at_root, (state_q != S_UP_CMP) || !sts_i.at_root, "parent compare at root")
  `BHPQ_ASSERT(a_result_from_done, !$rose(out_valid_q) || ($past(state_q) == S_DONE), "result raised outside done")

endmodule

/* hw/rtl/binary_heap_priority_queue.sv */
// Binary heap priority queue top level: channels, config register, controller and datapath.
// Sequencing: rejects and removal of the last entry go straight to the done state; an insert
//   climbs level by level toward the root; an extract first fetches and loads the last entry,
//   then descends level by level. Each level costs a read and a compare/write.
// One item at a time; the next transfer is taken while a result waits in the output register.
// Reset: heap empty, min-heap order; storage is not cleared and needs no clearing pass.
module binary_heap_priority_queue import bhpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  bhpq_in_if.sink               in_i,
  bhpq_out_if.source            out_o
);

  logic    order_q, order_d;
  logic    cfg_write;
  cmd_t    cmd;
  sts_t    sts;
  status_e status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    order_d = order_q;
    if (cfg_write && (paddr[2] == REG_HEAP_ORDER)) begin
      order_d = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_HEAP_ORDER) ? APB_DATA_W'(order_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else begin
      order_q <= order_d;
    end
  end

  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bhpq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .order_i         (order_q),
    .command_i       (in_i.command),
    .value_i         (in_i.value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .removed_value_o (out_o.removed_value),
    .top_value_o     (out_o.top_value),
    .entry_count_o   (out_o.entry_count),
    .status_o        (status)
  );

  assign out_o.status = status;

endmodule
